// File: sv/imh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types and constants for the indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int unsigned DefCapacity = 4096;
  localparam int unsigned DefCells    = 4096;

  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_DELETE  = 2'd1;
  localparam logic [1:0] ACT_REPLACE = 2'd2;
  localparam logic [1:0] ACT_NOP     = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_DUP    = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        cell_req;
    logic signed [31:0] value;
  } imh_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [12:0]        count;
    logic [11:0]        top_cell;
    logic signed [31:0] top_value;
  } imh_rsp_t;

endpackage
`default_nettype wire

// File: sv/indexed_min_heap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_heap
// Addressable binary min-heap of grid cells with a per-cell position map.
//
// Usage: drive req_i and raise start_i; the transaction is taken at an edge
// where busy_o is low. One result (status, count, top cell, top value)
// appears on rsp_o with done_o high for exactly one cycle; the receiver
// cannot stall it. busy_o is high from the cycle after acceptance until the
// result cycle, in which a new transaction can already be taken.
// A rejected or no-op request goes from the map lookup straight to the top
// read and the result. A delete or replace walks down with a read, a value
// fetch and a write per level and a check that ends it; a delete then moves
// the tail into the emptied slot unless that slot is the tail. An insert, a
// replace, or a delete that moved the tail walks up with a read, a value
// fetch and a compare-and-write per level, ending at the root or when a
// compare stops it. The rate is set by the synchronous memory reads at each
// tree level. After reset the block sweeps the position map clear, one
// entry a cycle, holding busy_o high; count is zero.
// ----------------------------------------------------------------------------
module indexed_min_heap #(
  parameter int unsigned CAPACITY = imh_pkg::DefCapacity,
  parameter int unsigned CELLS    = imh_pkg::DefCells
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire imh_pkg::imh_req_t req_i,
  output logic                  busy_o,
  output logic                  done_o,
  output imh_pkg::imh_rsp_t     rsp_o
);
  import imh_pkg::*;

  localparam int unsigned SW = $clog2(CAPACITY + 1);   // slot number width
  localparam int unsigned CW = (CELLS > 1) ? $clog2(CELLS) : 1;

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_MAP   = 15'b000000000000100,
    S_DNRD  = 15'b000000000001000,
    S_DNVAL = 15'b000000000010000,
    S_DNWR  = 15'b000000000100000,
    S_TAIL  = 15'b000000001000000,
    S_TAILV = 15'b000000010000000,
    S_TAILW = 15'b000000100000000,
    S_UPRD  = 15'b000001000000000,
    S_UPVAL = 15'b000010000000000,
    S_UPWR  = 15'b000100000000000,
    S_TOP   = 15'b001000000000000,
    S_TOPV  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_e;

  // memories; slot 0 is never used
  logic [CW-1:0]      slot_mem [0:CAPACITY];
  logic signed [31:0] val_mem  [0:CELLS-1];
  logic [SW-1:0]      pos_mem  [0:CELLS-1];

  state_e state_q, state_d;
  imh_req_t req_q;
  logic [SW-1:0] cnt_q, cur_q;
  logic [CW-1:0] cellx_q;        // cell being placed
  logic signed [31:0] valx_q;    // its value
  logic [CW-1:0] ca_q, cb_q;     // cells read from slots
  logic [1:0] st_q, st_d;
  logic [CW-1:0] clr_q;
  logic rsp_v_q;
  imh_rsp_t rsp_q;
  logic dir_q; // 1: delete

  // synchronous read ports, captured each cycle
  logic [SW-1:0] sa_addr, sb_addr;
  logic [CW-1:0] sa_rd, sb_rd;
  logic [CW-1:0] va_addr, vb_addr;
  logic signed [31:0] va_rd, vb_rd;
  logic [CW-1:0] p_addr;
  logic [SW-1:0] p_rd;

  logic          cell_ok;
  logic [CW-1:0] rcell;
  logic [SW:0]   left, right, cnt_x;
  logic          down_stop, right_none, pick_left, up_move;
  logic [CW-1:0] dn_cell;

  assign cell_ok    = ({{(32-12){1'b0}}, req_q.cell_req} < CELLS);
  assign rcell      = CW'(req_q.cell_req);
  assign left       = {cur_q, 1'b0};
  assign right      = left + 1'b1;
  assign cnt_x      = {1'b0, cnt_q};
  assign down_stop  = (left > cnt_x);
  assign right_none = (right > cnt_x);
  // ties pull the right child up
  assign pick_left  = right_none || (va_rd < vb_rd);
  assign dn_cell    = pick_left ? ca_q : cb_q;
  assign up_move    = (valx_q < va_rd);

  always_ff @(posedge clk_i) begin
    sa_rd <= slot_mem[sa_addr];
    sb_rd <= slot_mem[sb_addr];
    va_rd <= val_mem[va_addr];
    vb_rd <= val_mem[vb_addr];
    p_rd  <= pos_mem[p_addr];
  end

  // addresses per state
  always_comb begin
    sa_addr = SW'(1);
    sb_addr = SW'(1);
    va_addr = '0;
    vb_addr = '0;
    p_addr  = rcell;
    case (state_q)
      S_IDLE:  p_addr = CW'(req_i.cell_req);
      S_DNRD: begin
        if (!down_stop) begin
          sa_addr = left[SW-1:0];
          sb_addr = right_none ? left[SW-1:0] : right[SW-1:0];
        end
      end
      S_DNVAL: begin
        va_addr = sa_rd;
        vb_addr = sb_rd;
      end
      S_TAIL:  sa_addr = cnt_q;
      S_TAILV: va_addr = sa_rd;
      S_UPRD:  sa_addr = cur_q >> 1;
      S_UPVAL: va_addr = sa_rd;
      S_TOPV:  va_addr = sa_rd;
      default: ;
    endcase
  end

  always_comb begin
    st_d = ST_OK;
    if (req_q.action == ACT_NOP) st_d = ST_OK;
    else if (!cell_ok) st_d = ST_ABSENT;
    else if (req_q.action == ACT_INSERT) begin
      if (p_rd != '0) st_d = ST_DUP;
      else if ({{(32-SW){1'b0}}, cnt_q} >= CAPACITY) st_d = ST_FULL;
    end else if (p_rd == '0) st_d = ST_ABSENT;
  end

  // memory writes and datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_CLEAR: pos_mem[clr_q] <= '0;
      S_IDLE:  if (start_i) req_q <= req_i;
      S_MAP: begin
        cellx_q <= rcell;
        valx_q  <= req_q.value;
        if (st_d == ST_OK &&
            (req_q.action == ACT_INSERT || req_q.action == ACT_REPLACE)) begin
          val_mem[rcell] <= req_q.value;
        end
        if (st_d == ST_OK && req_q.action == ACT_DELETE) pos_mem[rcell] <= '0;
      end
      S_DNVAL: begin
        ca_q <= sa_rd;
        cb_q <= sb_rd;
      end
      S_DNWR: begin
        slot_mem[cur_q]  <= dn_cell;
        pos_mem[dn_cell] <= cur_q;
      end
      S_TAILV: cellx_q <= sa_rd;
      S_TAILW: valx_q  <= va_rd;
      S_UPRD: if (cur_q == SW'(1)) begin
        slot_mem[cur_q]  <= cellx_q;
        pos_mem[cellx_q] <= cur_q;
      end
      S_UPVAL: ca_q <= sa_rd;
      S_UPWR: if (up_move) begin
        slot_mem[cur_q] <= ca_q;
        pos_mem[ca_q]   <= cur_q;
      end else begin
        slot_mem[cur_q]  <= cellx_q;
        pos_mem[cellx_q] <= cur_q;
      end
      S_TOPV: ca_q <= sa_rd;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == CW'(CELLS - 1)) state_d = S_IDLE;
      S_IDLE:  if (start_i) state_d = S_MAP;
      S_MAP: begin
        if (st_d != ST_OK || req_q.action == ACT_NOP) state_d = S_TOP;
        else if (req_q.action == ACT_INSERT) state_d = S_UPRD;
        else state_d = S_DNRD;
      end
      S_DNRD: begin
        if (!down_stop) state_d = S_DNVAL;
        else if (!dir_q) state_d = S_UPRD;
        else if (cur_q != cnt_q) state_d = S_TAIL;
        else state_d = S_TOP;
      end
      S_DNVAL: state_d = S_DNWR;
      S_DNWR:  state_d = S_DNRD;
      S_TAIL:  state_d = S_TAILV;
      S_TAILV: state_d = S_TAILW;
      S_TAILW: state_d = S_UPRD;
      S_UPRD:  state_d = (cur_q == SW'(1)) ? S_TOP : S_UPVAL;
      S_UPVAL: state_d = S_UPWR;
      S_UPWR:  state_d = up_move ? S_UPRD : S_TOP;
      S_TOP:   state_d = S_TOPV;
      S_TOPV:  state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      rsp_v_q <= 1'b0;
      rsp_q   <= '0;
      cur_q   <= '0;
      st_q    <= ST_OK;
      dir_q   <= 1'b0;
    end else begin
      rsp_v_q <= (state_q == S_OUT);
      state_q <= state_d;
      case (state_q)
        S_CLEAR: clr_q <= clr_q + 1'b1;
        S_MAP: begin
          st_q  <= st_d;
          dir_q <= (req_q.action == ACT_DELETE);
          if (st_d == ST_OK && req_q.action == ACT_INSERT) begin
            cnt_q <= cnt_q + 1'b1;
            cur_q <= cnt_q + 1'b1;
          end else begin
            cur_q <= p_rd;
          end
        end
        // emptied slot is the tail itself
        S_DNRD:  if (down_stop && dir_q && cur_q == cnt_q) cnt_q <= cnt_q - 1'b1;
        S_DNWR:  cur_q <= pick_left ? left[SW-1:0] : right[SW-1:0];
        S_TAILV: cnt_q <= cnt_q - 1'b1;
        S_UPWR:  if (up_move) cur_q <= cur_q >> 1;
        S_OUT: begin
          rsp_q.status    <= st_q;
          rsp_q.count     <= 13'(cnt_q);
          rsp_q.top_cell  <= (cnt_q != '0) ? 12'(ca_q) : '0;
          rsp_q.top_value <= (cnt_q != '0) ? va_rd : '0;
        end
        default: ;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = rsp_v_q;
  assign rsp_o  = rsp_q;

endmodule
`default_nettype wire
